// ----- design/vsm_pkg.sv -----
// ----------------------------------------------------------------------------
// vsm_pkg: shared codes and port widths for the versioned snapshot memory
// Operation and status codes plus the fixed widths of the command and result
// fields.
// ----------------------------------------------------------------------------
package vsm_pkg;

  // Fixed field widths of the command and result ports
  localparam int OP_W      = 2;
  localparam int IDX_PW    = 10;
  localparam int VAL_PW    = 30;
  localparam int SNAP_PW   = 16;
  localparam int STATUS_W  = 2;
  localparam int ALEN_W    = 11;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Operation codes
  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_SNAP  = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  // Status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_BAD_INDEX = 2'd2;
  localparam status_t ST_NOT_TAKEN = 2'd3;

  // Reset value of the active length register
  localparam logic [ALEN_W-1:0] ALEN_RESET = 11'd1024;

endpackage

// ----- design/versioned_snapshot_memory_core.sv -----
// ----------------------------------------------------------------------------
// versioned_snapshot_memory_core: word memory with per-entry version history
// Each entry row holds a pair count and up to VERSIONS (snapshot, value)
// pairs in one synchronous RAM; a write command does a read-modify-write of one row.
// ----------------------------------------------------------------------------
// Flow: a taken command reads its row into a register; the row is updated
//   and written back in the execute state, which also registers the result strobe.
// A new command is not taken until the write-back of the last one is done;
//   busy is high in the write-back cycle.
// Reset: synchronous; after reset a clearing pass writes every row to a pair
//   count of one with the pair (0,0), busy stays high. Results cannot be stalled.
module versioned_snapshot_memory_core
  import vsm_pkg::*;
#(
  parameter int ENTRIES    = 1024,
  parameter int VERSIONS   = 8,
  parameter int SNAP_BITS  = 16,
  parameter int VALUE_BITS = 30
) (
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [IDX_PW-1:0]   in_entry_index,
  input  logic [VAL_PW-1:0]   in_write_value,
  input  logic [SNAP_PW-1:0]  in_query_snap,
  // result channel
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [VAL_PW-1:0]   out_read_value,
  output logic [SNAP_PW-1:0]  out_snap_number,
  // configuration
  input  logic                cfg_we,
  input  logic [ALEN_W-1:0]   cfg_wdata
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(VERSIONS + 1);
  localparam int VI_W   = $clog2(VERSIONS);
  localparam int PAIR_W = SNAP_BITS + VALUE_BITS;
  localparam int ROW_W  = CNT_W + VERSIONS * PAIR_W;
  localparam int LIM_W  = 18;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLEAR = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  localparam logic [ROW_W-1:0]     ROW_RESET = {CNT_W'(1), {(VERSIONS*PAIR_W){1'b0}}};
  localparam logic [SNAP_BITS-1:0] SNAP_MAX  = {SNAP_BITS{1'b1}};

  logic [ROW_W-1:0] mem [ENTRIES];

  logic [1:0]            state_r, state_nxt;
  logic [IDX_W-1:0]      clr_cnt_r;
  logic [ALEN_W-1:0]     active_length_r;
  logic [SNAP_BITS-1:0]  cur_snap_r, cur_snap_nxt;
  logic [ROW_W-1:0]      rd_row_r;

  logic [OP_W-1:0]       op_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  idx_ok_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [SNAP_BITS-1:0]  query_r;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [VAL_PW-1:0]     read_value_r, read_value_nxt;
  logic [SNAP_PW-1:0]    snap_number_r, snap_number_nxt;

  logic                  accept;
  logic                  idx_ok;
  logic [LIM_W-1:0]      limit;
  logic [IDX_W-1:0]      rd_addr;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ROW_W-1:0]      mem_wdata;
  logic                  exec_we;
  logic [ROW_W-1:0]      row_nxt;

  logic [CNT_W-1:0]      cnt;
  logic [VI_W-1:0]       top;
  logic [VI_W-1:0]       app;
  logic [SNAP_BITS-1:0]  snaps [VERSIONS];
  logic [VALUE_BITS-1:0] vals  [VERSIONS];
  logic [VERSIONS-1:0]   hit;
  logic [VALUE_BITS-1:0] found;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_status      = status_r;
  assign out_read_value  = read_value_r;
  assign out_snap_number = snap_number_r;

  // index check against min(active_length, ENTRIES)
  assign limit  = (LIM_W'(active_length_r) < LIM_W'(ENTRIES)) ?
                  LIM_W'(active_length_r) : LIM_W'(ENTRIES);
  assign idx_ok = LIM_W'(in_entry_index) < limit;
  assign rd_addr = IDX_W'(in_entry_index);

  // row unpack
  assign cnt = rd_row_r[ROW_W-1 -: CNT_W];
  assign top = VI_W'(cnt - CNT_W'(1));
  assign app = VI_W'(cnt);

  always_comb begin
    for (int k = 0; k < VERSIONS; k++) begin
      vals[k]  = rd_row_r[k*PAIR_W +: VALUE_BITS];
      snaps[k] = rd_row_r[k*PAIR_W + VALUE_BITS +: SNAP_BITS];
      hit[k]   = (CNT_W'(k) < cnt) && (snaps[k] <= query_r);
    end
  end

  // newest pair not above the query wins
  always_comb begin
    found = '0;
    for (int k = 0; k < VERSIONS; k++) begin
      if (hit[k]) begin
        found = vals[k];
      end
    end
  end

  // command execution on the fetched row
  always_comb begin
    row_nxt         = rd_row_r;
    exec_we         = 1'b0;
    status_nxt      = ST_OK;
    read_value_nxt  = '0;
    snap_number_nxt = '0;
    cur_snap_nxt    = cur_snap_r;
    case (op_r)
      OP_WRITE: begin
        if (!idx_ok_r) begin
          status_nxt = ST_BAD_INDEX;
        end else if (snaps[top] == cur_snap_r) begin
          row_nxt[top*PAIR_W +: VALUE_BITS] = val_r;
          exec_we = 1'b1;
        end else if (cnt >= CNT_W'(VERSIONS)) begin
          status_nxt = ST_FULL;
        end else begin
          row_nxt[app*PAIR_W +: PAIR_W] = {cur_snap_r, val_r};
          row_nxt[ROW_W-1 -: CNT_W]     = cnt + CNT_W'(1);
          exec_we = 1'b1;
        end
      end
      OP_SNAP: begin
        if (cur_snap_r == SNAP_MAX) begin
          status_nxt = ST_FULL;
        end else begin
          snap_number_nxt = SNAP_PW'(cur_snap_r);
          cur_snap_nxt    = cur_snap_r + SNAP_BITS'(1);
        end
      end
      OP_READ: begin
        if (!idx_ok_r) begin
          status_nxt = ST_BAD_INDEX;
        end else if (query_r >= cur_snap_r) begin
          status_nxt = ST_NOT_TAKEN;
        end else begin
          read_value_nxt = VAL_PW'(found);
        end
      end
      default: begin
      end
    endcase
  end

  // write port: clearing pass or write-back
  assign mem_we    = (state_r == S_CLEAR) || ((state_r == S_EXEC) && exec_we);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_cnt_r : idx_r;
  assign mem_wdata = (state_r == S_CLEAR) ? ROW_RESET : row_nxt;

  // row RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_row_r <= mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_cnt_r == IDX_W'(ENTRIES - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_cnt_r       <= '0;
      active_length_r <= ALEN_RESET;
      cur_snap_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_EXEC);
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
      if (cfg_we) begin
        active_length_r <= cfg_wdata;
      end
      if (state_r == S_EXEC) begin
        cur_snap_r <= cur_snap_nxt;
      end
    end
  end

  // command capture and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      idx_r    <= rd_addr;
      idx_ok_r <= idx_ok;
      val_r    <= VALUE_BITS'(in_write_value);
      query_r  <= SNAP_BITS'(in_query_snap);
    end
    if (state_r == S_EXEC) begin
      status_r      <= status_nxt;
      read_value_r  <= read_value_nxt;
      snap_number_r <= snap_number_nxt;
    end
  end

  // assertions
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EXEC))
    else $error("result beat without a preceding execute cycle");

  a_snap_only_on_snap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && op_r != OP_SNAP) |=> $stable(cur_snap_r))
    else $error("snapshot counter moved on a non-snapshot command");

  a_write_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_EXEC))
    else $error("row RAM written outside clear or execute");

  a_not_taken_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status != ST_OK) |-> (out_read_value == '0 && out_snap_number == '0))
    else $error("error result carries nonzero data");

endmodule
